### hw/rtl/sha256_pkg.sv
// Shared constants, types and bit functions of the SHA-256 byte stream hash unit.
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned LEN_FIRST   = 56;

  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Control of the block buffer / message schedule.
  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        mark;
    logic        put_len;
    logic        shift;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] len;
  } sched_ctl_t;

  // Control of the compression unit.
  typedef struct packed {
    logic init;
    logic step;
    logic add;
    logic reset_h;
  } round_ctl_t;

  function automatic logic [31:0] big0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### hw/rtl/sha256_sched.sv
// Block buffer that doubles as the sixteen-word message schedule window.
`timescale 1ns / 1ps

module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output logic [31:0]            w_cur
);

  logic [31:0] w_r   [sha256_pkg::BLOCK_WORDS];
  logic [31:0] w_nxt [sha256_pkg::BLOCK_WORDS];
  logic [31:0] w_new;

  assign w_cur = w_r[0];
  assign w_new = w_r[0] + sha256_pkg::sig0(w_r[1]) + w_r[9] + sha256_pkg::sig1(w_r[14]);

  always_comb begin
    for (int i = 0; i < sha256_pkg::BLOCK_WORDS; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctl.shift) begin
      // Word k of the window always holds schedule word t + k.
      for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[sha256_pkg::BLOCK_WORDS - 1] = w_new;
    end else if (ctl.wr_byte) begin
      for (int j = 0; j < 4; j++) begin
        if (ctl.pos[1:0] == 2'(j)) begin
          w_nxt[ctl.pos[5:2]][31 - 8 * j -: 8] = ctl.data;
        end
      end
    end else if (ctl.pad) begin
      for (int i = 0; i < sha256_pkg::BLOCK_WORDS; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(4 * i + j) == ctl.pos) begin
            w_nxt[i][31 - 8 * j -: 8] = ctl.mark ? sha256_pkg::PAD_MARK : 8'h00;
          end else if (6'(4 * i + j) > ctl.pos) begin
            w_nxt[i][31 - 8 * j -: 8] = 8'h00;
          end
        end
      end
      if (ctl.put_len) begin
        w_nxt[sha256_pkg::BLOCK_WORDS - 2] = ctl.len[63:32];
        w_nxt[sha256_pkg::BLOCK_WORDS - 1] = ctl.len[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sha256_pkg::BLOCK_WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

### hw/rtl/sha256_round.sv
// Compression unit: hash words, working variables and one shared round.
`timescale 1ns / 1ps

module sha256_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256_pkg::round_ctl_t ctl,
  input  logic [5:0]             rnd,
  input  logic [31:0]            w,
  input  logic [2:0]             rd_idx,
  output logic [31:0]            rd_word
);

  logic [31:0] hash_r [sha256_pkg::HASH_WORDS];
  logic [31:0] v_r    [sha256_pkg::HASH_WORDS];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  assign rd_word = hash_r[rd_idx];

  assign choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + sha256_pkg::big1(v_r[4]) + choose + sha256_pkg::ROUND_K[rnd] + w;
  assign t2 = sha256_pkg::big0(v_r[0]) + major;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= sha256_pkg::INIT_H[i];
      end
    end else if (ctl.reset_h) begin
      for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= sha256_pkg::INIT_H[i];
      end
    end else if (ctl.add) begin
      for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= hash_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
        v_r[i] <= hash_r[i];
      end
    end else if (ctl.step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

### hw/rtl/sha256_byte_stream_hash_unit.sv
// Throughput: one byte per cycle while a block fills; the 64th byte of a block stalls the
// input through the 64 rounds of the single round unit and the add.
// End of message: the padded last block is compressed, then a block of only the length when
// more than 55 bytes are buffered, then eight digest words follow, each held by any output stall.
// Reset (rst_n, synchronous, active low) loads the initial hash values and clears the
// counts and handshakes; the block buffer is undefined until written and is not cleared.
`timescale 1ns / 1ps

module sha256_byte_stream_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_LEN,
    S_OUT
  } state_t;

  state_t      state_r;
  logic [5:0]  fill_r;
  logic [63:0] bit_cnt_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic        pad_pend_r;
  logic        len_pend_r;
  logic        fin_r;
  logic        out_valid_r;
  logic [2:0]  out_idx_r;

  logic                   in_take;
  logic                   out_take;
  logic                   block_full;
  logic [63:0]            total;
  sha256_pkg::sched_ctl_t sctl;
  sha256_pkg::round_ctl_t rctl;
  logic [31:0]            w_cur;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign block_full = in_byte_present && (fill_r == 6'(sha256_pkg::BLOCK_BYTES - 1));
  assign total     = bit_cnt_r + {55'b0, fill_r, 3'b000};

  assign out_valid      = out_valid_r;
  assign out_word_index = out_idx_r;
  assign out_last_word  = (out_idx_r == 3'(sha256_pkg::HASH_WORDS - 1));

  always_comb begin
    sctl         = '0;
    sctl.pos     = fill_r;
    sctl.data    = in_data_byte;
    sctl.len     = len_r;
    rctl         = '0;
    unique case (state_r)
      S_IDLE: begin
        sctl.wr_byte = in_take && in_byte_present;
        rctl.init    = in_take && block_full;
      end
      S_PAD: begin
        // Marker after the last byte; the length fits only below byte 56.
        sctl.pad     = 1'b1;
        sctl.mark    = 1'b1;
        sctl.put_len = (fill_r < 6'(sha256_pkg::LEN_FIRST));
        sctl.len     = total;
        rctl.init    = 1'b1;
      end
      S_LEN: begin
        sctl.pad     = 1'b1;
        sctl.pos     = '0;
        sctl.put_len = 1'b1;
        rctl.init    = 1'b1;
      end
      S_ROUND: begin
        sctl.shift = 1'b1;
        rctl.step  = 1'b1;
      end
      S_ADD: begin
        rctl.add = 1'b1;
      end
      S_OUT: begin
        rctl.reset_h = out_take && out_last_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      bit_cnt_r   <= '0;
      rnd_r       <= '0;
      pad_pend_r  <= 1'b0;
      len_pend_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (block_full) begin
              fill_r     <= '0;
              bit_cnt_r  <= bit_cnt_r + sha256_pkg::BLOCK_BITS;
              pad_pend_r <= in_end_of_message;
              rnd_r      <= '0;
              state_r    <= S_ROUND;
            end else begin
              if (in_byte_present) begin
                fill_r <= fill_r + 6'd1;
              end
              if (in_end_of_message) begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          len_r      <= total;
          len_pend_r <= (fill_r >= 6'(sha256_pkg::LEN_FIRST));
          fin_r      <= 1'b1;
          bit_cnt_r  <= '0;
          fill_r     <= '0;
          rnd_r      <= '0;
          state_r    <= S_ROUND;
        end
        S_LEN: begin
          len_pend_r <= 1'b0;
          rnd_r      <= '0;
          state_r    <= S_ROUND;
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(sha256_pkg::ROUNDS - 1)) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (pad_pend_r) begin
            pad_pend_r <= 1'b0;
            state_r    <= S_PAD;
          end else if (len_pend_r) begin
            state_r <= S_LEN;
          end else if (fin_r) begin
            fin_r       <= 1'b0;
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_take) begin
            if (out_last_word) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_idx_r <= out_idx_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  sha256_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rctl),
    .rnd     (rnd_r),
    .w       (w_cur),
    .rd_idx  (out_idx_r),
    .rd_word (out_digest_word)
  );

endmodule

### hw/rtl/sha256_chk.sv
// Port-level checker of the SHA-256 byte stream hash unit, bound to the top level.
`timescale 1ns / 1ps

module sha256_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Digest words leave in order, one index further per transaction.
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest word index did not advance by one");

  // No input transaction is taken while the digest is being delivered.
  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while digest is pending");

  // Exactly eight words: the channel goes quiet after the last one.
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid)
    else $error("output valid after the last digest word");

  // An item that does not end the message produces no result next cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_end_of_message |=> !out_valid)
    else $error("result without end of message");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_digest_word) && $stable(out_word_index))
    else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hash_unit sha256_chk u_chk (.*);
